// ===== hw/rtl/opl_pkg.sv =====
// ----------------------------------------------------------------------------
// opl_pkg: shared types and constants for the ordered point list
// Operation codes, status codes, cell commands and default parameter values.
// ----------------------------------------------------------------------------
package opl_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int COORD_BITS_DEF = 16;
   localparam int KIND_BITS      = 3;
   localparam int STATUS_BITS    = 2;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_APPEND = 3'd0,
      KIND_INSERT = 3'd1,
      KIND_REMOVE = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_DUMP   = 3'd4
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_cmd_type;

endpackage

// ===== hw/rtl/opl_req_if.sv =====
// ----------------------------------------------------------------------------
// opl_req_if: request channel
// Valid/ready channel carrying one list operation per beat.
// ----------------------------------------------------------------------------
interface opl_req_if #(
   parameter int POS_BITS   = 5,
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic [2:0]                   kind;
   logic [POS_BITS-1:0]          position;
   logic signed [COORD_BITS-1:0] px;
   logic signed [COORD_BITS-1:0] py;

   modport source (output valid, kind, position, px, py, input ready);
   modport sink   (input valid, kind, position, px, py, output ready);
endinterface

// ===== hw/rtl/opl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// opl_rsp_if: response channel
// Valid/ready channel carrying one status or dumped point per beat.
// ----------------------------------------------------------------------------
interface opl_rsp_if #(
   parameter int CNT_BITS   = 5,
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [CNT_BITS-1:0]          count;
   logic                         has_point;
   logic signed [COORD_BITS-1:0] ox;
   logic signed [COORD_BITS-1:0] oy;
   logic                         last;

   modport source (output valid, status, count, has_point, ox, oy, last, input ready);
   modport sink   (input valid, status, count, has_point, ox, oy, last, output ready);
endinterface

// ===== hw/rtl/opl_cell.sv =====
// ----------------------------------------------------------------------------
// opl_cell: one entry of the point chain
// Holds one point; loads new data or takes a neighbor's or the head's point per command.
// ----------------------------------------------------------------------------
module opl_cell #(
   parameter int IDX        = 0,
   parameter int CNT_BITS   = 5,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  opl_pkg::cell_cmd_type        cmd,
   input  logic [CNT_BITS-1:0]          pos,
   input  logic [CNT_BITS-1:0]          fill,
   input  logic signed [COORD_BITS-1:0] new_x,
   input  logic signed [COORD_BITS-1:0] new_y,
   input  logic signed [COORD_BITS-1:0] prev_x,
   input  logic signed [COORD_BITS-1:0] prev_y,
   input  logic signed [COORD_BITS-1:0] next_x,
   input  logic signed [COORD_BITS-1:0] next_y,
   input  logic signed [COORD_BITS-1:0] head_x,
   input  logic signed [COORD_BITS-1:0] head_y,
   output logic signed [COORD_BITS-1:0] x_out,
   output logic signed [COORD_BITS-1:0] y_out
);
   import opl_pkg::*;

   localparam logic [CNT_BITS-1:0] IDX_V  = CNT_BITS'(IDX);
   localparam logic [CNT_BITS-1:0] IDX_P1 = CNT_BITS'(IDX + 1);

   logic signed [COORD_BITS-1:0] x_ff, y_ff;
   logic signed [COORD_BITS-1:0] x_in, y_in;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      unique case (cmd.op)
         CELL_APPEND: begin
            if (IDX_V == fill) begin
               x_in = new_x;
               y_in = new_y;
            end
         end
         CELL_INSERT: begin
            if (IDX_V == pos) begin
               x_in = new_x;
               y_in = new_y;
            end else if (IDX_V > pos) begin
               x_in = prev_x;
               y_in = prev_y;
            end
         end
         CELL_REMOVE: begin
            if (IDX_V >= pos) begin
               x_in = next_x;
               y_in = next_y;
            end
         end
         CELL_ROTATE: begin
            // tail of the live list wraps around to the head
            if (IDX_P1 == fill) begin
               x_in = head_x;
               y_in = head_y;
            end else begin
               x_in = next_x;
               y_in = next_y;
            end
         end
         default: begin
            x_in = x_ff;
            y_in = y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign x_out = x_ff;
   assign y_out = y_ff;

endmodule

// ===== hw/rtl/ordered_point_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// ordered_point_list_insert_remove: ordered list of signed (x,y) points
// Append, insert, remove, clear and dump over a chain of DEPTH point cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one operation per beat (kind, position, px, py).
//   rsp_ch returns one beat per edit operation with status and count, or one
//   beat per stored point for a dump, the final beat flagged by last.
//   Edits (append, insert, remove, clear) complete in the cycle the request
//   beat is taken: every cell shifts or loads in parallel. The response is
//   registered and visible the next cycle; one item per cycle while rsp_ch
//   keeps ready high.
//   A dump of N points enters the dump state, then streams N beats, one per
//   cycle while rsp_ch keeps ready high, by rotating the chain through cell
//   0; after N rotations the list is back in its original order. No request
//   is taken during a dump. An empty dump gives one beat with has_point low.
//   Reset empties the list (count zero); point storage is not cleared.
//   When rsp_ch stalls, the pending beat holds and req_ch ready drops until
//   the output register frees up.
// ----------------------------------------------------------------------------
module ordered_point_list_insert_remove #(
   parameter int DEPTH      = opl_pkg::DEPTH_DEF,
   parameter int COORD_BITS = opl_pkg::COORD_BITS_DEF,
   parameter int CNT_BITS   = $clog2(DEPTH + 1)
) (
   input logic   clock,
   input logic   reset,
   opl_req_if.sink   req_ch,
   opl_rsp_if.source rsp_ch
);
   import opl_pkg::*;

   localparam logic [CNT_BITS-1:0] DEPTH_V = CNT_BITS'(DEPTH);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   // control state
   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] fill_ff, fill_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // response payload
   status_type                   status_ff, status_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic                         has_ff, has_in;
   logic signed [COORD_BITS-1:0] ox_ff, ox_in;
   logic signed [COORD_BITS-1:0] oy_ff, oy_in;
   logic                         last_ff, last_in;

   logic         slot_free;
   logic         req_take;
   logic         dump_last;
   cell_cmd_type cmd;

   logic signed [COORD_BITS-1:0] x_q [DEPTH];
   logic signed [COORD_BITS-1:0] y_q [DEPTH];

   // output register is free when empty or being drained this cycle
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !reset && (state_ff == S_IDLE) && slot_free;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign dump_last    = (cnt_ff == CNT_BITS'(fill_ff - 1'b1));

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in    = status_ff;
      count_in     = count_ff;
      has_in       = has_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      last_in      = last_ff;
      cmd.op       = CELL_HOLD;

      if (req_take) begin
         // default: a single status beat
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         has_in       = 1'b0;
         ox_in        = '0;
         oy_in        = '0;
         last_in      = 1'b1;
         unique case (req_ch.kind)
            KIND_APPEND: begin
               if (fill_ff == DEPTH_V) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.op  = CELL_APPEND;
                  fill_in = fill_ff + 1'b1;
               end
            end
            KIND_INSERT: begin
               // position check wins over full check
               if (req_ch.position > fill_ff) begin
                  status_in = ST_BAD_POS;
               end else if (fill_ff == DEPTH_V) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.op  = CELL_INSERT;
                  fill_in = fill_ff + 1'b1;
               end
            end
            KIND_REMOVE: begin
               if (req_ch.position >= fill_ff) begin
                  status_in = ST_BAD_POS;
               end else begin
                  cmd.op  = CELL_REMOVE;
                  fill_in = fill_ff - 1'b1;
               end
            end
            KIND_CLEAR: begin
               fill_in = '0;
            end
            KIND_DUMP: begin
               // empty list answers at once; otherwise stream from the chain
               if (fill_ff != '0) begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_DUMP;
                  cnt_in       = '0;
               end
            end
            default: begin
               // unused kinds: plain ok beat, nothing changes
               status_in = ST_OK;
            end
         endcase
         count_in = fill_in;
      end else if (state_ff == S_DUMP && slot_free) begin
         cmd.op       = CELL_ROTATE;
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         count_in     = fill_ff;
         has_in       = 1'b1;
         ox_in        = x_q[0];
         oy_in        = y_q[0];
         last_in      = dump_last;
         cnt_in       = CNT_BITS'(cnt_ff + 1'b1);
         if (dump_last) begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      count_ff  <= count_in;
      has_ff    <= has_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      last_ff   <= last_in;
   end

   // chain of point cells; cell 0 is the list head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [COORD_BITS-1:0] prev_x, prev_y, next_x, next_y;

      if (i == 0) begin : g_first
         assign prev_x = req_ch.px;
         assign prev_y = req_ch.py;
      end else begin : g_mid_prev
         assign prev_x = x_q[i-1];
         assign prev_y = y_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_x = x_q[i];
         assign next_y = y_q[i];
      end else begin : g_mid_next
         assign next_x = x_q[i+1];
         assign next_y = y_q[i+1];
      end

      opl_cell #(
         .IDX        (i),
         .CNT_BITS   (CNT_BITS),
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock  (clock),
         .cmd    (cmd),
         .pos    (req_ch.position),
         .fill   (fill_ff),
         .new_x  (req_ch.px),
         .new_y  (req_ch.py),
         .prev_x (prev_x),
         .prev_y (prev_y),
         .next_x (next_x),
         .next_y (next_y),
         .head_x (x_q[0]),
         .head_y (y_q[0]),
         .x_out  (x_q[i]),
         .y_out  (y_q[i])
      );
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.count     = count_ff;
   assign rsp_ch.has_point = has_ff;
   assign rsp_ch.ox        = ox_ff;
   assign rsp_ch.oy        = oy_ff;
   assign rsp_ch.last      = last_ff;

`ifndef NO_ASSERTIONS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_V)
      else $error("list size beyond capacity");

   a_dump_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |-> cnt_ff < fill_ff)
      else $error("dump index past list end");

   a_dump_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |=> $stable(fill_ff))
      else $error("list size changed during dump");

   a_point_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && has_ff |-> status_ff == ST_OK && count_ff != '0)
      else $error("dumped point with bad status or empty count");
`endif

endmodule

// ===== bench/ordered_point_list_insert_remove_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_point_list_insert_remove_tb: self-checking bench for the point list
// Directed edge cases and then random append/insert/remove/clear/dump traffic
// with random gaps on both channels. Every reply beat is checked against a
// shadow list that this bench keeps for itself.
// ----------------------------------------------------------------------------
module ordered_point_list_insert_remove_tb;
   import opl_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int CBITS       = COORD_BITS_DEF;
   localparam int POS_BITS    = 5;
   localparam int CNT_BITS    = $clog2(DEPTH + 1);
   localparam int RANDOM_OPS  = 200;
   localparam int MAX_SHOWN   = 10;
   localparam int IDLE_PCT    = 21;
   localparam int SETTLE      = 20;
   // ~250 beats in, a dump can return 16 beats and each may sit in a stall:
   // 250 * 16 reply beats with their stalls fit well under this
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [2:0]              kind;
      logic [POS_BITS-1:0]     position;
      logic signed [CBITS-1:0] px;
      logic signed [CBITS-1:0] py;
      bit                      drain;   // hold this beat until all replies are in
   } list_op_type;

   typedef struct {
      logic [1:0]              status;
      logic [CNT_BITS-1:0]     count;
      logic                    has_point;
      logic signed [CBITS-1:0] ox;
      logic signed [CBITS-1:0] oy;
      logic                    last;
   } list_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   opl_req_if #(.POS_BITS(POS_BITS), .COORD_BITS(CBITS)) req_ch ();
   opl_rsp_if #(.CNT_BITS(CNT_BITS), .COORD_BITS(CBITS)) rsp_ch ();

   ordered_point_list_insert_remove #(
      .DEPTH      (DEPTH),
      .COORD_BITS (CBITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Shadow list: the points the block should hold, and the reply beats that
   // accepted requests still owe us, oldest first.
   // ------------------------------------------------------------------------
   logic signed [CBITS-1:0] list_x [DEPTH];
   logic signed [CBITS-1:0] list_y [DEPTH];
   int                      list_fill = 0;
   list_reply_type          list_replies [$];

   list_op_type pending_ops [$];   // request beats not yet presented
   logic        req_taken = 1'b0;  // request beat accepted at the last rising edge
   int          ops_taken = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   logic        calm;

   // Apply one accepted request to the shadow list and queue its reply beats
   function automatic void apply_list_op(input list_op_type op);
      list_reply_type r;
      logic [1:0]     st;
      int             pos;
      st  = ST_OK;
      pos = op.position;
      case (op.kind)
         KIND_APPEND: begin
            if (list_fill >= DEPTH) begin
               st = ST_FULL;
            end else begin
               list_x[list_fill] = op.px;
               list_y[list_fill] = op.py;
               list_fill++;
            end
         end
         KIND_INSERT: begin
            // a bad position wins over a full list
            if (pos > list_fill) begin
               st = ST_BAD_POS;
            end else if (list_fill >= DEPTH) begin
               st = ST_FULL;
            end else begin
               for (int i = list_fill; i > pos; i--) begin
                  list_x[i] = list_x[i-1];
                  list_y[i] = list_y[i-1];
               end
               list_x[pos] = op.px;
               list_y[pos] = op.py;
               list_fill++;
            end
         end
         KIND_REMOVE: begin
            if (pos >= list_fill) begin
               st = ST_BAD_POS;
            end else begin
               for (int i = pos; i < list_fill - 1; i++) begin
                  list_x[i] = list_x[i+1];
                  list_y[i] = list_y[i+1];
               end
               list_fill--;
            end
         end
         KIND_CLEAR: begin
            list_fill = 0;
         end
         default: ;   // dump handled below, unused kinds change nothing
      endcase

      if (op.kind == KIND_DUMP && list_fill > 0) begin
         // one beat per stored point, in list order
         for (int i = 0; i < list_fill; i++) begin
            r.status    = ST_OK;
            r.count     = CNT_BITS'(list_fill);
            r.has_point = 1'b1;
            r.ox        = list_x[i];
            r.oy        = list_y[i];
            r.last      = (i == list_fill - 1);
            list_replies.push_back(r);
         end
      end else begin
         r.status    = st;
         r.count     = CNT_BITS'(list_fill);
         r.has_point = 1'b0;
         r.ox        = '0;
         r.oy        = '0;
         r.last      = 1'b1;
         list_replies.push_back(r);
      end
   endfunction

   function automatic void flag_mismatch(input string what, input list_reply_type want,
                                         input list_reply_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN)
         $display("%0t mismatch (%0s): expected st=%0d cnt=%0d pt=%0b x=%0d y=%0d last=%0b",
                  $realtime, what, want.status, want.count, want.has_point, want.ox,
                  want.oy, want.last);
      if (mismatch_count <= MAX_SHOWN)
         $display("%0t           got      st=%0d cnt=%0d pt=%0b x=%0d y=%0d last=%0b",
                  $realtime, got.status, got.count, got.has_point, got.ox, got.oy,
                  got.last);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic signed [CBITS-1:0] rand_coord();
      case ($urandom_range(7))
         0: return {1'b1, {(CBITS-1){1'b0}}};   // most negative
         1: return {1'b0, {(CBITS-1){1'b1}}};   // most positive
         2: return $urandom_range(1) ? '0 : '1;  // zero / minus one
         default: return CBITS'($urandom);
      endcase
   endfunction

   function automatic void queue_op(input logic [2:0] kind, input int pos,
                                    input logic signed [CBITS-1:0] x,
                                    input logic signed [CBITS-1:0] y);
      list_op_type op;
      op.kind     = kind;
      op.position = POS_BITS'(pos);
      op.px       = x;
      op.py       = y;
      op.drain    = 1'b0;
      pending_ops.push_back(op);
   endfunction

   // Long stretch with no gaps on either side
   assign calm = (ops_taken >= 90) && (ops_taken < 140);

   // ------------------------------------------------------------------------
   // Request driver: new beats at the falling edge; a beat that is not yet
   // taken holds. Valid is assigned at most once per edge.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      list_op_type nxt;
      logic        go;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!(req_ch.valid && !req_taken)) begin
         go = (pending_ops.size() > 0) && (calm || $urandom_range(99) >= IDLE_PCT);
         // pressure point: wait for every owed reply before this beat goes out
         if (go && pending_ops[0].drain && list_replies.size() != 0)
            go = 1'b0;
         if (go) begin
            nxt = pending_ops.pop_front();
            req_ch.kind     <= nxt.kind;
            req_ch.position <= nxt.position;
            req_ch.px       <= nxt.px;
            req_ch.py       <= nxt.py;
            req_ch.valid    <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Reply side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: at each rising edge check a taken reply beat against the oldest
   // owed one, then fold a taken request beat into the shadow list. A reply
   // never comes from the request taken at the same edge, so this order holds.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      list_reply_type want;
      list_reply_type got;
      list_op_type    op;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status    = rsp_ch.status;
            got.count     = rsp_ch.count;
            got.has_point = rsp_ch.has_point;
            got.ox        = rsp_ch.ox;
            got.oy        = rsp_ch.oy;
            got.last      = rsp_ch.last;
            if (list_replies.size() == 0) begin
               want = '{default: '0};
               flag_mismatch("beat with nothing owed", want, got);
            end else begin
               want = list_replies.pop_front();
               if (got.status !== want.status || got.count !== want.count ||
                   got.has_point !== want.has_point || got.ox !== want.ox ||
                   got.oy !== want.oy || got.last !== want.last)
                  flag_mismatch("field", want, got);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            op.kind     = req_ch.kind;
            op.position = req_ch.position;
            op.px       = req_ch.px;
            op.py       = req_ch.py;
            op.drain    = 1'b0;
            apply_list_op(op);
            ops_taken++;
         end
         req_taken <= req_ch.valid && req_ch.ready;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int   gen_fill;
      int   made;
      int   pick;
      int   pos;
      bit   grow;
      logic [2:0] kind;

      req_ch.valid    = 1'b0;
      req_ch.kind     = '0;
      req_ch.position = '0;
      req_ch.px       = '0;
      req_ch.py       = '0;
      rsp_ch.ready    = 1'b0;

      // -- directed: empty list corners
      queue_op(KIND_DUMP,   0, '0, '0);                  // empty dump, single beat
      queue_op(KIND_REMOVE, 0, '0, '0);                  // remove on empty list
      queue_op(KIND_INSERT, 1, '0, '0);                  // insert past end
      queue_op(KIND_INSERT, 0, {1'b1, {(CBITS-1){1'b0}}}, {1'b0, {(CBITS-1){1'b1}}});
      // -- fill up to two short of full, then insert at the end and middle
      for (int i = 0; i < 13; i++)
         queue_op(KIND_APPEND, 31, rand_coord(), rand_coord());
      queue_op(KIND_INSERT, 14, {1'b0, {(CBITS-1){1'b1}}}, {1'b1, {(CBITS-1){1'b0}}});
      queue_op(KIND_INSERT, 5, '1, '0);                  // list now full
      queue_op(KIND_APPEND, 0, '1, '1);                  // full
      queue_op(KIND_INSERT, 3, '0, '1);                  // full, good position
      queue_op(KIND_INSERT, 17, '0, '0);                 // bad position beats full
      queue_op(KIND_REMOVE, 16, '0, '0);                 // remove at size
      queue_op(KIND_REMOVE, 15, '0, '0);                 // drop the tail
      queue_op(KIND_REMOVE, 0, '0, '0);                  // drop the head
      queue_op(KIND_DUMP,   0, '0, '0);
      queue_op(3'd5, 31, '1, '1);                        // unused kinds
      queue_op(3'd6, 0, '0, '0);
      queue_op(3'd7, 16, rand_coord(), rand_coord());
      queue_op(KIND_CLEAR,  0, '0, '0);
      queue_op(KIND_DUMP,   0, '0, '0);                  // empty again after clear

      // -- random: swing between growing and shrinking phases so the list
      //    spends time both full and empty; most positions are in range
      gen_fill = 0;
      made     = 0;
      grow     = 1'b1;
      while (made < RANDOM_OPS) begin
         if (gen_fill == 0)
            grow = 1'b1;
         else if (gen_fill >= DEPTH && $urandom_range(3) == 0)
            grow = 1'b0;
         pick = $urandom_range(99);
         if (pick < 3) begin
            kind = 3'($urandom_range(7, 5));
         end else if (pick < 5) begin
            kind = KIND_CLEAR;
         end else if (pick < 17) begin
            kind = KIND_DUMP;
         end else if (pick < (grow ? 50 : 27)) begin
            kind = KIND_APPEND;
         end else if (pick < (grow ? 84 : 38)) begin
            kind = KIND_INSERT;
         end else begin
            kind = KIND_REMOVE;
         end

         if (kind == KIND_INSERT)
            pos = ($urandom_range(99) < 85) ? $urandom_range(gen_fill) : $urandom_range(31);
         else if (kind == KIND_REMOVE && gen_fill > 0 && $urandom_range(99) < 85)
            pos = $urandom_range(gen_fill - 1);
         else
            pos = $urandom_range(31);

         queue_op(kind, pos, rand_coord(), rand_coord());

         // track the size only, to steer positions and phases
         case (kind)
            KIND_APPEND: if (gen_fill < DEPTH) gen_fill++;
            KIND_INSERT: if (pos <= gen_fill && gen_fill < DEPTH) gen_fill++;
            KIND_REMOVE: if (pos < gen_fill) gen_fill--;
            KIND_CLEAR:  gen_fill = 0;
            default: ;
         endcase

         if (kind <= KIND_DUMP) begin
            made++;
            if (made == 60 || made == 150)
               pending_ops[pending_ops.size()-1].drain = 1'b1;
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all request beats taken, then all replies in, then a quiet tail
      while (pending_ops.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (list_replies.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== ordered_point_list_insert_remove.f =====
hw/rtl/opl_pkg.sv
hw/rtl/opl_req_if.sv
hw/rtl/opl_rsp_if.sv
hw/rtl/opl_cell.sv
hw/rtl/ordered_point_list_insert_remove.sv
bench/ordered_point_list_insert_remove_tb.sv
